// ===== hdl/msta_pkg.sv =====
// Shared constants, codes and the raw-to-sixteenths conversion for the sensor averager.
package msta_pkg;

  localparam int unsigned NUM_SENSORS_DEF      = 16;
  localparam int unsigned SENSORS_PER_BANK_DEF = 4;

  localparam int unsigned OPC_W   = 2;
  localparam int unsigned SENS_W  = 4;
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned BANK_W  = 2;
  localparam int unsigned VAL_W   = 13;  // sixteenths and tenths, signed
  localparam int unsigned FLAGS_W = 4;
  localparam int unsigned ACC_W   = 18;  // holds 5 * (3-sample sum)
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // opcodes
  localparam logic [OPC_W-1:0] OP_READING  = 2'd0;
  localparam logic [OPC_W-1:0] OP_CLEAR    = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ_AVG = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP      = 2'd3;

  // average limits in tenths
  localparam logic signed [VAL_W-1:0] AVG_MIN = -13'sd2550;
  localparam logic signed [VAL_W-1:0] AVG_MAX = 13'sd1279;

  // ceil(2^17 / 3): exact floor(n / 3) for n below 2^15
  localparam logic [15:0] RECIP3 = 16'hAAAB;

  localparam logic [RAW_W-1:0] NEG_LIMIT = 16'h0800;

  typedef enum logic [1:0] {
    ALU_LOAD,
    ALU_ADD,
    ALU_MUL5,
    ALU_DIV24
  } alu_op_e;

  function automatic logic signed [VAL_W-1:0] to_sixteenths(input logic [RAW_W-1:0] raw);
    logic [7:0]              mag;
    logic signed [VAL_W-1:0] res;
    mag = 8'(8'd0 - raw[11:4]);
    if (raw < NEG_LIMIT) begin
      res = $signed({2'b00, raw[10:0]});
    end else begin
      res = $signed({9'd0, raw[3:0]}) - $signed({1'b0, mag, 4'd0});
    end
    return res;
  endfunction

endpackage

// ===== hdl/msta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/msta_alu.sv =====
// Shared arithmetic unit: load, accumulate, times five, truncating divide by 24.
module msta_alu import msta_pkg::*; (
  input  alu_op_e                 op_i,
  input  logic signed [ACC_W-1:0] acc_i,
  input  logic signed [VAL_W-1:0] opnd_i,
  output logic signed [ACC_W-1:0] res_o
);

  logic             acc_neg;
  logic [ACC_W-1:0] acc_mag;
  logic [13:0]      eighth;
  logic [29:0]      prod;
  logic [VAL_W-1:0] quot;

  always_comb begin
    acc_neg = acc_i[ACC_W-1];
    acc_mag = acc_neg ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    // |x|/24 = (|x|/8)/3, the /3 by reciprocal multiply
    eighth  = acc_mag[16:3];
    prod    = eighth * RECIP3;
    quot    = prod[29:17];
    case (op_i)
      ALU_LOAD:  res_o = ACC_W'(opnd_i);
      ALU_ADD:   res_o = acc_i + ACC_W'(opnd_i);
      ALU_MUL5:  res_o = (acc_i <<< 2) + acc_i;
      ALU_DIV24: res_o = acc_neg ? $signed(ACC_W'(0) - ACC_W'(quot)) : $signed(ACC_W'(quot));
      default:   res_o = acc_i;
    endcase
  end

endmodule

// ===== hdl/multi_sensor_temp_average_change_unit.sv =====
// Top level: multi-sensor temperature averager with per-bank change flags.
//
// channel  | dir | tdata (low bit first)                          | tuser
// ---------+-----+------------------------------------------------+-------------
// s_axis   | in  | sensor[3:0] raw_word[19:4] check_ok[20]        | opcode[1:0]
//          |     | bank[22:21], zero pad [23]                     |
// m_axis   | out | average_tenths[12:0] updated[13]               | -
//          |     | bank_flags[17:14], zero pad [23:18]            |
//
// Sequence: a sensor reading steps through load, convert, sum of three history
//   terms, x5, /24, compare and hand-off before the next accept; the history
//   RAM's single read port and the one shared ALU force these steps in turn.
//   Clear-flag, read-average and no-op words go through load and hand-off only.
// Reset: rst_ni async, active low. All stores read as zero after reset
//   through per-entry valid bits; no clearing pass is needed.
// Stalls: one word in flight. The result sits in the output register, so a
//   new word is taken while it waits; the next result waits in its hand-off
//   state until the output register frees up.
module multi_sensor_temp_average_change_unit import msta_pkg::*; #(
  parameter int unsigned NUM_SENSORS      = NUM_SENSORS_DEF,
  parameter int unsigned SENSORS_PER_BANK = SENSORS_PER_BANK_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // sensor[3:0], raw_word[19:4], check_ok[20], bank[22:21]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode[1:0]
  input  logic [OPC_W-1:0]      s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // average_tenths[12:0], updated[13], bank_flags[17:14]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned NUM_BANKS  = (NUM_SENSORS + SENSORS_PER_BANK - 1) / SENSORS_PER_BANK;
  localparam int unsigned SA_W       = $clog2(NUM_SENSORS);
  localparam int unsigned HA_W       = SA_W + 2;
  localparam int unsigned HIST_DEPTH = NUM_SENSORS * 4;
  localparam int unsigned BI_W       = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int unsigned FX_W       = (NUM_BANKS > FLAGS_W) ? NUM_BANKS : FLAGS_W;
  localparam int unsigned CMP_W      = 8;
  localparam int unsigned PAD_W      = OUT_DATA_W - FLAGS_W - 1 - VAL_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_CONV = 4'd2;
  localparam logic [3:0] ST_SUM1 = 4'd3;
  localparam logic [3:0] ST_SUM2 = 4'd4;
  localparam logic [3:0] ST_MUL5 = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_CMP  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_q, state_d;

  // latched input word
  logic [OPC_W-1:0]  op_q;
  logic [SENS_W-1:0] sens_q;
  logic [RAW_W-1:0]  raw_q;
  logic              ok_q;
  logic [BANK_W-1:0] bank_q;

  // control state
  logic [1:0]                  slot_q, slot_d;
  logic [NUM_BANKS-1:0]        flags_q, flags_d;
  logic [NUM_SENSORS-1:0]      lr_vld_q, lr_vld_d;
  logic [NUM_SENSORS-1:0]      av_vld_q, av_vld_d;
  logic [HIST_DEPTH-1:0]       hist_vld_q, hist_vld_d;
  logic                        out_valid_q, out_valid_d;

  // datapath registers
  logic                        lr_hit_q, av_hit_q, hist_hit_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [VAL_W-1:0]     val_q, val_d;
  logic signed [VAL_W-1:0]     res_avg_q, res_avg_d;
  logic                        res_upd_q, res_upd_d;
  logic [OUT_DATA_W-1:0]       out_data_q;

  // RAM ports
  logic                        lr_we, lr_re, av_we, av_re, hist_we, hist_re;
  logic [HA_W-1:0]             hist_waddr, hist_raddr;
  logic [RAW_W-1:0]            lr_rdata;
  logic [VAL_W-1:0]            av_rdata, hist_rdata;

  // ALU
  alu_op_e                     alu_op;
  logic signed [VAL_W-1:0]     alu_opnd;
  logic signed [ACC_W-1:0]     alu_res;
  logic                        acc_en;

  logic                        s_accept;
  logic                        out_load;
  logic [SA_W-1:0]             sens_a;
  logic                        in_rng;
  logic                        is_last;
  logic [1:0]                  slot_e;
  logic [BI_W-1:0]             sbank;
  logic [RAW_W-1:0]            raw_sel;
  logic signed [VAL_W-1:0]     conv;
  logic signed [VAL_W-1:0]     lr_unused_guard;
  logic signed [VAL_W-1:0]     hist_rd_m, av_rd_m;
  logic signed [VAL_W-1:0]     new_avg;
  logic signed [VAL_W-1:0]     out_avg;
  logic [FX_W-1:0]             flags_ext;
  logic [FLAGS_W-1:0]          flags_vis;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign sens_a  = SA_W'(sens_q);
  assign in_rng  = CMP_W'(sens_q) < CMP_W'(NUM_SENSORS);
  assign is_last = CMP_W'(sens_q) == CMP_W'(NUM_SENSORS - 1);
  assign slot_e  = (slot_q > 2'd2) ? 2'd0 : slot_q;

  // bank of the addressed sensor: last threshold passed wins
  always_comb begin
    sbank = '0;
    for (int b = 1; b < NUM_BANKS; b++) begin
      if (CMP_W'(sens_q) >= CMP_W'(b * SENSORS_PER_BANK)) begin
        sbank = BI_W'(b);
      end
    end
  end

  // never-written entries read as zero
  assign raw_sel         = ok_q ? raw_q : (lr_hit_q ? lr_rdata : '0);
  assign conv            = to_sixteenths(raw_sel);
  assign lr_unused_guard = conv;
  assign hist_rd_m       = hist_hit_q ? $signed(hist_rdata) : '0;
  assign av_rd_m         = av_hit_q ? $signed(av_rdata) : '0;
  assign new_avg         = acc_q[VAL_W-1:0];

  msta_alu u_alu (
    .op_i   (alu_op),
    .acc_i  (acc_q),
    .opnd_i (alu_opnd),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    flags_d     = flags_q;
    lr_vld_d    = lr_vld_q;
    av_vld_d    = av_vld_q;
    hist_vld_d  = hist_vld_q;
    val_d       = val_q;
    res_avg_d   = res_avg_q;
    res_upd_d   = res_upd_q;
    lr_we       = 1'b0;
    lr_re       = 1'b0;
    av_we       = 1'b0;
    av_re       = 1'b0;
    hist_we     = 1'b0;
    hist_re     = 1'b0;
    hist_waddr  = {sens_a, slot_e};
    hist_raddr  = {sens_a, 2'd0};
    alu_op      = ALU_ADD;
    alu_opnd    = hist_rd_m;
    acc_en      = 1'b0;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // fetch last raw, stored average and history slot 0 together
        lr_re     = in_rng;
        av_re     = in_rng;
        hist_re   = in_rng;
        res_avg_d = '0;
        res_upd_d = 1'b0;
        if ((op_q == OP_READING) && in_rng) begin
          if (ok_q) begin
            lr_we            = 1'b1;
            lr_vld_d[sens_a] = 1'b1;
          end
          state_d = ST_CONV;
        end else begin
          if ((op_q == OP_CLEAR) && (CMP_W'(bank_q) < CMP_W'(NUM_BANKS))) begin
            flags_d[BI_W'(bank_q)] = 1'b0;
          end
          state_d = ST_DONE;
        end
      end
      ST_CONV: begin
        hist_we                = 1'b1;
        hist_vld_d[hist_waddr] = 1'b1;
        hist_re                = 1'b1;
        hist_raddr             = {sens_a, 2'd1};
        val_d                  = lr_unused_guard;
        alu_op                 = ALU_LOAD;
        alu_opnd               = (slot_e == 2'd0) ? conv : hist_rd_m;
        acc_en                 = 1'b1;
        state_d                = ST_SUM1;
      end
      ST_SUM1: begin
        hist_re    = 1'b1;
        hist_raddr = {sens_a, 2'd2};
        alu_opnd   = (slot_e == 2'd1) ? val_q : hist_rd_m;
        acc_en     = 1'b1;
        state_d    = ST_SUM2;
      end
      ST_SUM2: begin
        alu_opnd = (slot_e == 2'd2) ? val_q : hist_rd_m;
        acc_en   = 1'b1;
        state_d  = ST_MUL5;
      end
      ST_MUL5: begin
        alu_op  = ALU_MUL5;
        acc_en  = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        alu_op  = ALU_DIV24;
        acc_en  = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (new_avg != av_rd_m) begin
          av_we            = 1'b1;
          av_vld_d[sens_a] = 1'b1;
          flags_d[sbank]   = 1'b1;
          res_upd_d        = 1'b1;
        end
        res_avg_d = new_avg;
        if (is_last) begin
          slot_d = (slot_e == 2'd2) ? 2'd0 : slot_e + 2'd1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result word
  always_comb begin
    if (op_q == OP_READING) begin
      out_avg = res_avg_q;
    end else if ((op_q == OP_READ_AVG) && in_rng) begin
      out_avg = av_rd_m;
    end else begin
      out_avg = '0;
    end
    flags_ext = FX_W'(flags_q);
    flags_vis = flags_ext[FLAGS_W-1:0];
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      flags_q     <= '0;
      lr_vld_q    <= '0;
      av_vld_q    <= '0;
      hist_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      flags_q     <= flags_d;
      lr_vld_q    <= lr_vld_d;
      av_vld_q    <= av_vld_d;
      hist_vld_q  <= hist_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q   <= s_axis_tuser_i;
      sens_q <= s_axis_tdata_i[3:0];
      raw_q  <= s_axis_tdata_i[19:4];
      ok_q   <= s_axis_tdata_i[20];
      bank_q <= s_axis_tdata_i[22:21];
    end
    // valid bits captured alongside each RAM read
    if (lr_re) begin
      lr_hit_q <= lr_vld_q[sens_a];
    end
    if (av_re) begin
      av_hit_q <= av_vld_q[sens_a];
    end
    if (hist_re) begin
      hist_hit_q <= hist_vld_q[hist_raddr];
    end
    if (acc_en) begin
      acc_q <= alu_res;
    end
    val_q     <= val_d;
    res_avg_q <= res_avg_d;
    res_upd_q <= res_upd_d;
    if (out_load) begin
      out_data_q <= {PAD_W'(0), flags_vis, res_upd_q, out_avg};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // last good raw word per sensor
  msta_ram #(
    .WIDTH (RAW_W),
    .DEPTH (NUM_SENSORS)
  ) u_lr_ram (
    .clk_i   (clk_i),
    .we_i    (lr_we),
    .waddr_i (sens_a),
    .wdata_i (raw_q),
    .re_i    (lr_re),
    .raddr_i (sens_a),
    .rdata_o (lr_rdata)
  );

  // stored average per sensor, tenths
  msta_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NUM_SENSORS)
  ) u_av_ram (
    .clk_i   (clk_i),
    .we_i    (av_we),
    .waddr_i (sens_a),
    .wdata_i (new_avg),
    .re_i    (av_re),
    .raddr_i (sens_a),
    .rdata_o (av_rdata)
  );

  // three-slot history, row of four per sensor (slot 3 unused)
  msta_ram #(
    .WIDTH (VAL_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (conv),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

endmodule

// ===== hdl/msta_chk.sv =====
// Port-level checker for the sensor averager, bound to the top level.
module msta_chk import msta_pkg::*; #(
  parameter int unsigned NUM_SENSORS      = NUM_SENSORS_DEF,
  parameter int unsigned SENSORS_PER_BANK = SENSORS_PER_BANK_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [OPC_W-1:0]      s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned NUM_BANKS = (NUM_SENSORS + SENSORS_PER_BANK - 1) / SENSORS_PER_BANK;
  localparam logic        FLAGS_ALL_SHOWN = (NUM_BANKS <= FLAGS_W);

  logic signed [VAL_W-1:0] avg_w;
  assign avg_w = $signed(m_axis_tdata_o[12:0]);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("accepted a second word while busy");

  // averages stay in the range the conversion allows
  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (avg_w >= AVG_MIN) && (avg_w <= AVG_MAX))
    else $error("average out of range");

  // a changed average always leaves a bank flag set (checked when every bank fits in the flag field)
  a_upd_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FLAGS_ALL_SHOWN && m_axis_tvalid_o && m_axis_tdata_o[13] |-> m_axis_tdata_o[17:14] != '0)
    else $error("update without a bank flag");

endmodule

bind multi_sensor_temp_average_change_unit msta_chk #(
  .NUM_SENSORS      (NUM_SENSORS),
  .SENSORS_PER_BANK (SENSORS_PER_BANK)
) u_msta_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/sv/msta_avg_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sensor averager: tracks averages and bank flags and checks each readout.
package msta_avg_tb_pkg;
  import msta_pkg::*;

  localparam int unsigned NUM_BANKS =
    (NUM_SENSORS_DEF + SENSORS_PER_BANK_DEF - 1) / SENSORS_PER_BANK_DEF;

  typedef struct packed {
    logic signed [VAL_W-1:0] avg;
    logic                    updated;
    logic [FLAGS_W-1:0]      flags;
  } readout_t;

  class avg_flag_checker;
    logic [RAW_W-1:0]        good_raw [NUM_SENSORS_DEF];
    logic signed [VAL_W-1:0] samples  [NUM_SENSORS_DEF][3];
    logic [1:0]              slot_ptr;
    logic signed [VAL_W-1:0] avg_tenths [NUM_SENSORS_DEF];
    logic [NUM_BANKS-1:0]    bank_changed;
    readout_t                readouts_due[$];
    int unsigned             fails;

    function new();
      for (int s = 0; s < NUM_SENSORS_DEF; s++) begin
        good_raw[s]   = '0;
        avg_tenths[s] = '0;
        for (int k = 0; k < 3; k++) samples[s][k] = '0;
      end
      slot_ptr     = '0;
      bank_changed = '0;
      fails        = 0;
    endfunction

    // raw scratchpad word -> sixteenths; upper range uses the wrapped-magnitude rule
    function automatic int raw_to_sixteenths(logic [RAW_W-1:0] raw);
      logic [7:0] steps;
      steps = 8'd0 - raw[11:4];
      if (raw < NEG_LIMIT) return int'(raw);
      return int'(raw[3:0]) - 16 * int'(steps);
    endfunction

    function void note_word(logic [OPC_W-1:0] opc, logic [IN_DATA_W-1:0] data);
      logic [SENS_W-1:0] sensor;
      logic [RAW_W-1:0]  raw;
      logic              ok;
      logic [BANK_W-1:0] bank;
      logic [1:0]        slot;
      int                sum;
      int                avg;
      readout_t          r;
      sensor = data[3:0];
      raw    = data[19:4];
      ok     = data[20];
      bank   = data[22:21];
      r      = '0;
      case (opc)
        OP_READING: begin
          slot = (slot_ptr > 2'd2) ? 2'd0 : slot_ptr;
          if (ok) good_raw[sensor] = raw;
          samples[sensor][slot] = VAL_W'(raw_to_sixteenths(good_raw[sensor]));
          sum = int'(samples[sensor][0]) + int'(samples[sensor][1]) +
                int'(samples[sensor][2]);
          avg = (5 * sum) / 24;  // truncates toward zero
          if (avg != int'(avg_tenths[sensor])) begin
            avg_tenths[sensor] = VAL_W'(avg);
            bank_changed[sensor / SENSORS_PER_BANK_DEF] = 1'b1;
            r.updated = 1'b1;
          end
          if (sensor == NUM_SENSORS_DEF - 1) slot_ptr = (slot >= 2'd2) ? 2'd0 : slot + 2'd1;
          r.avg = avg_tenths[sensor];
        end
        OP_CLEAR: begin
          if (bank < NUM_BANKS) bank_changed[bank] = 1'b0;
        end
        OP_READ_AVG: begin
          r.avg = avg_tenths[sensor];
        end
        default: ;
      endcase
      r.flags = FLAGS_W'(bank_changed);
      readouts_due = {readouts_due, r};
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data);
      readout_t                want;
      logic signed [VAL_W-1:0] got_avg;
      got_avg = data[12:0];
      if (readouts_due.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, data);
        fails++;
        return;
      end
      want = readouts_due.pop_front();
      if (got_avg !== want.avg) begin
        $display("%0t: average_tenths expected %0d actual %0d", $time, want.avg, got_avg);
        fails++;
      end
      if (data[13] !== want.updated) begin
        $display("%0t: updated expected %0b actual %0b", $time, want.updated, data[13]);
        fails++;
      end
      if (data[17:14] !== want.flags) begin
        $display("%0t: bank_flags expected %b actual %b", $time, want.flags, data[17:14]);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return readouts_due.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_multi_sensor_temp_average_change_unit.sv =====
`timescale 1ns / 1ps
// Testbench top: drives the sensor averager with random handshakes and checks every readout.
module tb_multi_sensor_temp_average_change_unit;
  import msta_pkg::*;
  import msta_avg_tb_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1700;
  localparam int unsigned HOLD_AT      = 400;  // readout count where the sink goes quiet
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // sensor[3:0], raw_word[19:4], check_ok[20], bank[22:21]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  // opcode[1:0]
  logic [OPC_W-1:0]      s_axis_tuser_i  = OP_NOP;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // average_tenths[12:0], updated[13], bank_flags[17:14]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  avg_flag_checker board;

  // per-sensor "room temperature" in sixteenths, so most readings hover near it
  int          base_temp [NUM_SENSORS_DEF];
  int unsigned words_sent;
  int unsigned readouts_seen;

  multi_sensor_temp_average_change_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("multi_sensor_temp_average_change_unit regression: fail");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_word(logic [SENS_W-1:0] sensor,
                                                     logic [RAW_W-1:0] raw,
                                                     logic ok, logic [BANK_W-1:0] bank);
    return {1'b0, bank, ok, raw, sensor};
  endfunction

  // Offer one word; valid stays high across back-to-back words (no drop/raise in one step).
  // Prediction happens at the accepting edge, well ahead of the readout.
  task automatic send_word(logic [OPC_W-1:0] opc, logic [IN_DATA_W-1:0] data);
    int gap;
    // every third stretch of 150 words runs with no gaps at all
    gap = ((words_sent / 150) % 3 == 2) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= opc;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_word(opc, data);
    words_sent++;
  endtask

  task automatic send_reading(logic [SENS_W-1:0] sensor, logic [RAW_W-1:0] raw, logic ok);
    send_word(OP_READING, pack_word(sensor, raw, ok, BANK_W'($urandom)));
  endtask

  // Raw word for a sensor: mostly near its base (steady averages and small drifts),
  // sometimes fully random to hit every bit and the odd upper-range encodings.
  function automatic logic [RAW_W-1:0] pick_raw(int sensor);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) base_temp[sensor] = int'($urandom_range(0, 2880)) - 880;
    if (r < 30) return RAW_W'(base_temp[sensor]);
    if (r < 75) return RAW_W'(base_temp[sensor] + int'($urandom_range(0, 6)) - 3);
    return RAW_W'($urandom);
  endfunction

  // Sink: random hold-offs per readout, stretches with none, and one long stall so the
  // block backs up and deasserts s_axis_tready_o while the source keeps offering.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (readouts_seen == HOLD_AT) gap = HOLD_CYCLES;
      else if ((readouts_seen / 130) % 3 == 1) gap = 0;
      else gap = $urandom_range(0, 7);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      board.check_word(m_axis_tdata_o);
      readouts_seen++;
    end
  end

  initial begin
    int sweep_sensor;
    int r;
    board         = new();
    words_sent    = 0;
    readouts_seen = 0;
    for (int s = 0; s < NUM_SENSORS_DEF; s++) base_temp[s] = int'($urandom_range(0, 2880)) - 880;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // Fill all three slots of sensor 0 with the top positive word and sensor 1 with
    // an upper-range negative word; sensor 15 readings step the shared slot pointer.
    send_reading(4'd0, 16'h07FF, 1'b1);
    send_reading(4'd1, 16'h0810, 1'b1);
    send_reading(4'd15, 16'h0800, 1'b1);   // lowest upper-range word
    send_reading(4'd0, 16'h07FF, 1'b1);
    send_reading(4'd1, 16'h0810, 1'b1);
    send_reading(4'd15, 16'hFFFF, 1'b1);
    send_reading(4'd0, 16'h07FF, 1'b1);    // average reaches its maximum
    send_reading(4'd1, 16'h0810, 1'b1);    // every slot holds the same negative sample
    // Readings that fail the check fall back to the last good raw word
    send_reading(4'd2, 16'h07D0, 1'b0);
    send_reading(4'd2, 16'hFC90, 1'b1);
    send_reading(4'd2, 16'hABCD, 1'b0);
    send_reading(4'd3, 16'h0000, 1'b1);
    send_reading(4'd15, 16'h0000, 1'b1);   // pointer wraps back to slot 0
    send_word(OP_READ_AVG, pack_word(4'd0, 16'h0000, 1'b0, 2'd0));
    send_word(OP_READ_AVG, pack_word(4'd1, 16'hFFFF, 1'b1, 2'd3));
    send_word(OP_READ_AVG, pack_word(4'd15, 16'h5A5A, 1'b1, 2'd1));
    for (int b = 0; b < NUM_BANKS; b++)
      send_word(OP_CLEAR, pack_word(4'd15 - SENS_W'(b), 16'hFFFF, 1'b1, BANK_W'(b)));
    send_word(OP_NOP, pack_word(4'd7, 16'hFFFF, 1'b1, 2'd3));
    send_word(OP_READ_AVG, pack_word(4'd2, 16'h1234, 1'b1, 2'd2));

    // --- random ---
    // Mostly in-order sweeps over all sensors so every history slot gets used,
    // interleaved with flag clears, readbacks, no-ops and stray readings.
    sweep_sensor = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_reading(SENS_W'(sweep_sensor), pick_raw(sweep_sensor),
                     ($urandom_range(0, 9) != 0));
        sweep_sensor = (sweep_sensor + 1) % NUM_SENSORS_DEF;
      end else if (r < 83) begin
        send_word(OP_CLEAR, pack_word(SENS_W'($urandom), RAW_W'($urandom), 1'($urandom),
                                      BANK_W'($urandom)));
      end else if (r < 93) begin
        send_word(OP_READ_AVG, pack_word(SENS_W'($urandom), RAW_W'($urandom), 1'($urandom),
                                         BANK_W'($urandom)));
      end else if (r < 96) begin
        send_word(OP_NOP, pack_word(SENS_W'($urandom), RAW_W'($urandom), 1'($urandom),
                                    BANK_W'($urandom)));
      end else begin
        send_reading(SENS_W'($urandom), RAW_W'($urandom), 1'($urandom));
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fails == 0) begin
      $display("multi_sensor_temp_average_change_unit regression: pass");
    end else begin
      $display("multi_sensor_temp_average_change_unit regression: fail");
    end
    $finish;
  end

endmodule
